// ===== design/midi_tep_pkg.sv =====
package midi_tep_pkg;

    localparam logic [2:0] PH_DELTA  = 3'd0;
    localparam logic [2:0] PH_STATUS = 3'd1;
    localparam logic [2:0] PH_CHAN   = 3'd2;
    localparam logic [2:0] PH_MTYPE  = 3'd3;
    localparam logic [2:0] PH_LEN    = 3'd4;
    localparam logic [2:0] PH_BODY   = 3'd5;

    localparam logic [1:0] KIND_CHAN  = 2'd0;
    localparam logic [1:0] KIND_META  = 2'd1;
    localparam logic [1:0] KIND_SYSEX = 2'd2;
    localparam logic [1:0] KIND_SYS   = 2'd3;

    localparam logic [7:0] ST_META     = 8'hFF;
    localparam logic [7:0] ST_SYSEX    = 8'hF0;
    localparam logic [7:0] ST_ESCAPE   = 8'hF7;
    localparam logic [7:0] ST_ONE_LO   = 8'hC0;
    localparam logic [7:0] ST_ONE_HI   = 8'hDF;
    localparam logic [3:0] ST_SYS_NIB  = 4'hF;

    localparam int Q_DEPTH = 3;

    typedef struct packed {
        logic [31:0] tick;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        valid;
        logic        first;
        logic        last;
    } t_result;

    function automatic t_result mk_result(
        input logic [31:0] tick,
        input logic [1:0]  kind,
        input logic [7:0]  data,
        input logic        valid,
        input logic        first,
        input logic        last
    );
        t_result r;
        r.tick  = tick;
        r.kind  = kind;
        r.data  = valid ? data : 8'h00;
        r.valid = valid;
        r.first = first;
        r.last  = last;
        return r;
    endfunction

endpackage

// ===== design/midi_track_event_parser_top.sv =====
// Channel   Dir  Beat fields (tdata / tuser / tlast)
// s_axis    in   tdata: track_byte[7:0]; tuser: track_start[0]
// m_axis    out  tdata: event_tick[31:0], out_byte[39:32];
//                tuser: event_kind[1:0], byte_valid[2], event_first[3]; tlast: event_last
//
// One input beat is parsed in the cycle it is accepted; its results land in a
// three-slot result queue, whose head register drives m_axis.
// Sustained rate is one byte per cycle while m_axis is ready; a byte giving two
// results (running status replay) holds off input until the single result port drains.
// s_axis_tready is high while the queue holds at most one result.
// Reset is synchronous, active low: delta phase, tick and running status cleared.
module midi_track_event_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // track_byte[7:0]
    input  logic [0:0]  s_axis_tuser,   // track_start[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // event_tick[31:0], out_byte[39:32]
    output logic [3:0]  m_axis_tuser,   // event_kind[1:0], byte_valid[2], event_first[3]
    output logic        m_axis_tlast
);

    logic [2:0]  r_phase, n_phase;
    logic [31:0] r_tick, n_tick;
    logic [7:0]  r_run, n_run;
    logic [31:0] r_acc, n_acc;
    logic [1:0]  r_cbl, n_cbl;
    logic [1:0]  r_kind, n_kind;

    midi_tep_pkg::t_result r_q [midi_tep_pkg::Q_DEPTH];
    midi_tep_pkg::t_result n_q [midi_tep_pkg::Q_DEPTH];
    logic [1:0] r_count, n_count;

    midi_tep_pkg::t_result res0, res1;
    logic v0, v1;
    logic accept, pop, push0, push1;
    logic [1:0] base;

    assign s_axis_tready = (r_count < 2'd2);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_count != 2'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;

    assign m_axis_tdata = {r_q[0].data, r_q[0].tick};
    assign m_axis_tuser = {r_q[0].first, r_q[0].valid, r_q[0].kind};
    assign m_axis_tlast = r_q[0].last;

    always_comb begin
        logic [2:0]  ph;
        logic [31:0] tick;
        logic [7:0]  rs;
        logic [7:0]  st;
        logic [7:0]  b;
        logic [31:0] acc;
        logic [1:0]  cbl;
        logic [1:0]  kind;
        logic        replay;
        logic        proc_en;
        logic        pv;
        midi_tep_pkg::t_result pr;

        ph   = r_phase;
        tick = r_tick;
        rs   = r_run;
        acc  = r_acc;
        cbl  = r_cbl;
        kind = r_kind;
        b    = s_axis_tdata;
        st   = 8'h00;
        pv   = 1'b0;
        pr   = '0;
        res0 = '0;
        res1 = '0;
        v0   = 1'b0;
        v1   = 1'b0;

        if (s_axis_tuser[0]) begin
            ph   = midi_tep_pkg::PH_DELTA;
            tick = 32'd0;
            rs   = 8'h00;
            acc  = 32'd0;
            cbl  = 2'd0;
            kind = midi_tep_pkg::KIND_CHAN;
        end

        replay  = (ph == midi_tep_pkg::PH_STATUS) && !b[7];
        proc_en = (ph != midi_tep_pkg::PH_STATUS);

        // status position: take new status or replay the stored one
        if (ph == midi_tep_pkg::PH_STATUS) begin
            st = b[7] ? b : rs;
            rs = st;
            v0 = 1'b1;
            if (st[7:4] != midi_tep_pkg::ST_SYS_NIB) begin
                kind = midi_tep_pkg::KIND_CHAN;
                res0 = midi_tep_pkg::mk_result(tick, kind, st, 1'b1, 1'b1, 1'b0);
                cbl  = (st >= midi_tep_pkg::ST_ONE_LO && st <= midi_tep_pkg::ST_ONE_HI)
                       ? 2'd1 : 2'd2;
                ph   = midi_tep_pkg::PH_CHAN;
            end else if (st == midi_tep_pkg::ST_META) begin
                kind = midi_tep_pkg::KIND_META;
                res0 = midi_tep_pkg::mk_result(tick, kind, st, 1'b1, 1'b1, 1'b0);
                ph   = midi_tep_pkg::PH_MTYPE;
            end else if (st == midi_tep_pkg::ST_SYSEX || st == midi_tep_pkg::ST_ESCAPE) begin
                kind = midi_tep_pkg::KIND_SYSEX;
                res0 = midi_tep_pkg::mk_result(tick, kind, st, 1'b1, 1'b1, 1'b0);
                acc  = 32'd0;
                ph   = midi_tep_pkg::PH_LEN;
            end else begin
                kind = midi_tep_pkg::KIND_SYS;
                res0 = midi_tep_pkg::mk_result(tick, kind, 8'h00, 1'b0, 1'b1, 1'b1);
                acc  = 32'd0;
                ph   = midi_tep_pkg::PH_DELTA;
            end
            proc_en = replay;
        end

        if (proc_en) begin
            unique case (ph)
                midi_tep_pkg::PH_STATUS: begin
                end
                midi_tep_pkg::PH_CHAN: begin
                    cbl = cbl - 2'd1;
                    pv  = 1'b1;
                    pr  = midi_tep_pkg::mk_result(tick, kind, b, 1'b1, 1'b0, cbl == 2'd0);
                    if (cbl == 2'd0) begin
                        acc = 32'd0;
                        ph  = midi_tep_pkg::PH_DELTA;
                    end
                end
                midi_tep_pkg::PH_MTYPE: begin
                    pv  = 1'b1;
                    pr  = midi_tep_pkg::mk_result(tick, kind, b, 1'b1, 1'b0, 1'b0);
                    acc = 32'd0;
                    ph  = midi_tep_pkg::PH_LEN;
                end
                midi_tep_pkg::PH_LEN: begin
                    acc = {acc[24:0], b[6:0]};
                    if (!b[7]) begin
                        if (acc == 32'd0) begin
                            pv = 1'b1;
                            pr = midi_tep_pkg::mk_result(tick, kind, 8'h00, 1'b0, 1'b0, 1'b1);
                            ph = midi_tep_pkg::PH_DELTA;
                        end else begin
                            ph = midi_tep_pkg::PH_BODY;
                        end
                    end
                end
                midi_tep_pkg::PH_BODY: begin
                    acc = acc - 32'd1;
                    pv  = 1'b1;
                    pr  = midi_tep_pkg::mk_result(tick, kind, b, 1'b1, 1'b0, acc == 32'd0);
                    if (acc == 32'd0) begin
                        ph = midi_tep_pkg::PH_DELTA;
                    end
                end
                default: begin
                    acc = {acc[24:0], b[6:0]};
                    if (!b[7]) begin
                        tick = tick + acc;
                        acc  = 32'd0;
                        ph   = midi_tep_pkg::PH_STATUS;
                    end else begin
                        ph   = midi_tep_pkg::PH_DELTA;
                    end
                end
            endcase
            if (replay) begin
                res1 = pr;
                v1   = pv;
            end else begin
                res0 = pr;
                v0   = pv;
            end
        end

        n_phase = ph;
        n_tick  = tick;
        n_run   = rs;
        n_acc   = acc;
        n_cbl   = cbl;
        n_kind  = kind;
    end

    assign push0 = accept && v0;
    assign push1 = accept && v1;
    assign base  = r_count - {1'b0, pop};

    always_comb begin
        for (int i = 0; i < midi_tep_pkg::Q_DEPTH; i++) begin
            if (pop && i < midi_tep_pkg::Q_DEPTH - 1) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (push0 && base == 2'(i)) begin
                n_q[i] = res0;
            end
            if (push1 && (base + 2'd1) == 2'(i)) begin
                n_q[i] = res1;
            end
        end
        n_count = r_count - {1'b0, pop} + {1'b0, push0} + {1'b0, push1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= midi_tep_pkg::PH_DELTA;
            r_tick  <= 32'd0;
            r_run   <= 8'h00;
            r_acc   <= 32'd0;
            r_cbl   <= 2'd0;
            r_kind  <= midi_tep_pkg::KIND_CHAN;
            r_count <= 2'd0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_run   <= n_run;
                r_acc   <= n_acc;
                r_cbl   <= n_cbl;
                r_kind  <= n_kind;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    a_marker_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata[39:32] == 8'h00)
        else $error("bare marker beat carries a data byte");

    a_sys_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == midi_tep_pkg::KIND_SYS
        |-> m_axis_tuser[3] && m_axis_tlast && !m_axis_tuser[2])
        else $error("system status event not a single bare marker");

    a_start_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_axis_tuser[0] && s_axis_tdata[7] |=> r_phase == midi_tep_pkg::PH_DELTA)
        else $error("continued delta byte at track start left delta phase");

    a_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push1 |-> push0 && r_count <= 2'd1)
        else $error("second result pushed without room or first result");

endmodule
